// ===== hdl/avba_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// avba_pkg
// Shared types and constants of the aligned vector block allocator.
// ----------------------------------------------------------------------------
package avba_pkg;

  localparam int NUM_VECTORS = 256;
  localparam int VEC_W       = $clog2(NUM_VECTORS);
  localparam int CNT_W       = VEC_W + 1;
  localparam int CFG_IDX_W   = 1;
  localparam int CFG_DATA_W  = CNT_W;
  localparam int IN_DATA_W   = 32;
  localparam int OUT_DATA_W  = 16;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NOT_READY = 2'd1,
    ST_INVALID   = 2'd2,
    ST_NO_BLOCK  = 2'd3
  } status_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ENABLED  = 1'b0,
    REG_CAPACITY = 1'b1
  } reg_idx_e;

  localparam logic [CNT_W-1:0] NUM_VECTORS_C = CNT_W'(NUM_VECTORS);

  // Busy map access: a single address serves either a read or a write.
  typedef struct packed {
    logic             rd_en;
    logic             we;
    logic [VEC_W-1:0] addr;
    logic             wdata;
  } map_req_t;

  typedef struct packed {
    status_e          status;
    logic [VEC_W-1:0] base;
  } result_t;

endpackage

// ===== hdl/avba_map.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// avba_map
// Busy map memory, one bit per vector, with a clearing pass after reset.
// ----------------------------------------------------------------------------
module avba_map (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  avba_pkg::map_req_t req_i,
  output logic              rdata_o,
  output logic              clearing_o
);
  import avba_pkg::*;

  logic             mem [NUM_VECTORS];
  logic             clearing_q, clearing_d;
  logic [VEC_W-1:0] clr_cnt_q, clr_cnt_d;
  logic             rdata_q;
  logic             wr_en;
  logic [VEC_W-1:0] wr_addr;
  logic             wr_data;

  always_comb begin
    clearing_d = clearing_q;
    clr_cnt_d  = clr_cnt_q;
    if (clearing_q) begin
      clr_cnt_d = clr_cnt_q + VEC_W'(1);
      if (clr_cnt_q == VEC_W'(NUM_VECTORS - 1)) begin
        clearing_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clearing_q <= 1'b1;
      clr_cnt_q  <= '0;
    end else begin
      clearing_q <= clearing_d;
      clr_cnt_q  <= clr_cnt_d;
    end
  end

  assign wr_en   = clearing_q | req_i.we;
  assign wr_addr = clearing_q ? clr_cnt_q : req_i.addr;
  assign wr_data = clearing_q ? 1'b0 : req_i.wdata;

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (req_i.rd_en) begin
      rdata_q <= mem[req_i.addr];
    end
  end

  assign rdata_o    = rdata_q;
  assign clearing_o = clearing_q;

endmodule

// ===== hdl/avba_alu.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// avba_alu
// Shared adder and limit compare: over = (a + b + cin) > lim.
// ----------------------------------------------------------------------------
module avba_alu (
  input  logic [avba_pkg::CNT_W-1:0] a_i,
  input  logic [avba_pkg::CNT_W-1:0] b_i,
  input  logic                       cin_i,
  input  logic [avba_pkg::CNT_W-1:0] lim_i,
  output logic                       over_o
);
  import avba_pkg::*;

  logic [CNT_W:0] sum;

  assign sum    = {1'b0, a_i} + {1'b0, b_i} + {{CNT_W{1'b0}}, cin_i};
  assign over_o = sum > {1'b0, lim_i};

endmodule

// ===== hdl/avba_seq.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// avba_seq
// Request sequencer: checks arguments, scans the busy map one vector per
// cycle for the first aligned free run, then marks or clears the run.
// ----------------------------------------------------------------------------
module avba_seq (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       enabled_i,
  input  logic [avba_pkg::CNT_W-1:0] cap_i,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic                       in_cmd_i,
  input  logic [avba_pkg::CNT_W-1:0] in_count_i,
  input  logic [avba_pkg::CNT_W-1:0] in_align_i,
  input  logic [avba_pkg::VEC_W-1:0] in_base_i,
  output logic                       res_valid_o,
  input  logic                       res_ready_i,
  output avba_pkg::result_t          res_o,
  output avba_pkg::map_req_t         map_req_o,
  input  logic                       map_rdata_i,
  input  logic                       map_clearing_i
);
  import avba_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_SCAN,
    S_MARK,
    S_DONE
  } state_e;

  state_e           state_q;
  logic             cmd_q;
  logic [CNT_W-1:0] count_q;
  logic [CNT_W-1:0] align_q;
  logic [VEC_W-1:0] base_q;
  logic [VEC_W-1:0] amask_q;
  logic [CNT_W-1:0] start_q;
  logic [CNT_W-1:0] ptr_q;
  logic [VEC_W-1:0] rd_addr_q;
  logic             rd_pend_q;
  logic [CNT_W-1:0] rem_q;
  logic [VEC_W-1:0] mptr_q;
  logic             mark_val_q;
  result_t          res_q;

  logic [CNT_W-1:0] align_eff;
  logic [CNT_W-1:0] align_m1;
  logic             align_bad;
  logic [CNT_W-1:0] alu_a;
  logic             alu_cin;
  logic             alu_over;
  logic [CNT_W-1:0] next_start;

  assign align_eff = (align_q == '0) ? CNT_W'(1) : align_q;
  assign align_m1  = align_eff - CNT_W'(1);
  assign align_bad = (align_eff & align_m1) != '0;

  // CHECK: base + count against capacity; SCAN: end of the next candidate run.
  assign alu_a      = (state_q == S_CHECK) ? {1'b0, base_q} : {1'b0, rd_addr_q | amask_q};
  assign alu_cin    = (state_q != S_CHECK);
  assign next_start = {1'b0, rd_addr_q | amask_q} + CNT_W'(1);

  avba_alu u_alu (
    .a_i    (alu_a),
    .b_i    (count_q),
    .cin_i  (alu_cin),
    .lim_i  (cap_i),
    .over_o (alu_over)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      cmd_q      <= 1'b0;
      count_q    <= '0;
      align_q    <= '0;
      base_q     <= '0;
      amask_q    <= '0;
      start_q    <= '0;
      ptr_q      <= '0;
      rd_addr_q  <= '0;
      rd_pend_q  <= 1'b0;
      rem_q      <= '0;
      mptr_q     <= '0;
      mark_val_q <= 1'b0;
      res_q      <= '{status: ST_OK, base: '0};
    end else begin
      unique case (state_q)
        S_IDLE: begin
          if (in_valid_i && in_ready_o) begin
            cmd_q   <= in_cmd_i;
            count_q <= in_count_i;
            align_q <= in_align_i;
            base_q  <= in_base_i;
            state_q <= S_CHECK;
          end
        end
        S_CHECK: begin
          res_q.base <= '0;
          if (!enabled_i) begin
            res_q.status <= ST_NOT_READY;
            state_q      <= S_DONE;
          end else if (!cmd_q) begin
            if (count_q == '0 || count_q > cap_i || align_bad) begin
              res_q.status <= ST_INVALID;
              state_q      <= S_DONE;
            end else begin
              amask_q   <= align_m1[VEC_W-1:0];
              start_q   <= '0;
              ptr_q     <= '0;
              rd_pend_q <= 1'b0;
              rem_q     <= count_q;
              state_q   <= S_SCAN;
            end
          end else begin
            if (count_q == '0 || alu_over) begin
              res_q.status <= ST_INVALID;
              state_q      <= S_DONE;
            end else begin
              res_q.status <= ST_OK;
              mptr_q       <= base_q;
              rem_q        <= count_q;
              mark_val_q   <= 1'b0;
              state_q      <= S_MARK;
            end
          end
        end
        S_SCAN: begin
          // The read issued this cycle returns next cycle with its address.
          rd_addr_q <= ptr_q[VEC_W-1:0];
          if (rd_pend_q && map_rdata_i) begin
            // Busy vector: jump to the next aligned start past it.
            rd_pend_q <= 1'b0;
            if (alu_over) begin
              res_q.status <= ST_NO_BLOCK;
              state_q      <= S_DONE;
            end else begin
              start_q <= next_start;
              ptr_q   <= next_start;
              rem_q   <= count_q;
            end
          end else if (rd_pend_q && rem_q == CNT_W'(1)) begin
            res_q.status <= ST_OK;
            res_q.base   <= start_q[VEC_W-1:0];
            mptr_q       <= start_q[VEC_W-1:0];
            rem_q        <= count_q;
            mark_val_q   <= 1'b1;
            rd_pend_q    <= 1'b0;
            state_q      <= S_MARK;
          end else begin
            if (rd_pend_q) begin
              rem_q <= rem_q - CNT_W'(1);
            end
            ptr_q     <= ptr_q + CNT_W'(1);
            rd_pend_q <= 1'b1;
          end
        end
        S_MARK: begin
          mptr_q <= mptr_q + VEC_W'(1);
          rem_q  <= rem_q - CNT_W'(1);
          if (rem_q == CNT_W'(1)) begin
            state_q <= S_DONE;
          end
        end
        S_DONE: begin
          if (res_ready_i) begin
            state_q <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign in_ready_o  = (state_q == S_IDLE) && !map_clearing_i;
  assign res_valid_o = (state_q == S_DONE);
  assign res_o       = res_q;

  assign map_req_o.rd_en = (state_q == S_SCAN);
  assign map_req_o.we    = (state_q == S_MARK);
  assign map_req_o.addr  = (state_q == S_MARK) ? mptr_q : ptr_q[VEC_W-1:0];
  assign map_req_o.wdata = mark_val_q;

endmodule

// ===== hdl/aligned_vector_block_allocator.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aligned_vector_block_allocator
// First-fit allocator of aligned contiguous vector runs over a busy map.
// ----------------------------------------------------------------------------
// After reset the busy map is swept clear, one vector per cycle;
// s_axis_tready stays low during that pass, configuration writes are
// taken. One item is served at a time. A free is checked, clears its run
// and hands off its result. An allocate is checked, then the scan reads
// the busy map one vector per cycle through its single port, restarting
// at the next aligned start past each busy vector it meets, then marks
// the run and hands off the result. Rejected requests (disabled, bad
// arguments) answer straight after the check. The next item is accepted
// while a finished result still waits in the output register.
// ----------------------------------------------------------------------------
module aligned_vector_block_allocator (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  // Configuration write port
  input  logic                                 cfg_we_i,
  input  logic [avba_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [avba_pkg::CFG_DATA_W-1:0]      cfg_wdata_i,
  // Request items
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  // [8:0] count, [17:9] alignment, [25:18] base, [31:26] zero
  input  logic [avba_pkg::IN_DATA_W-1:0]       s_axis_tdata,
  // [0] cmd (0 allocate, 1 free)
  input  logic                                 s_axis_tuser,
  // Result items
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  // [1:0] status, [9:2] base_out, [15:10] zero
  output logic [avba_pkg::OUT_DATA_W-1:0]      m_axis_tdata
);
  import avba_pkg::*;

  logic             enabled_q;
  logic [CNT_W-1:0] capacity_q;
  logic [CNT_W-1:0] eff_cap;

  logic             res_valid;
  logic             res_ready;
  result_t          res;
  map_req_t         map_req;
  logic             map_rdata;
  logic             map_clearing;

  logic             out_valid_q;
  result_t          out_q;

  // Hold the configuration registers; the map itself survives a disable.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enabled_q  <= 1'b0;
      capacity_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_ENABLED:  enabled_q  <= cfg_wdata_i[0];
        REG_CAPACITY: capacity_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Clamp the capacity to the size of the busy map.
  assign eff_cap = (capacity_q > NUM_VECTORS_C) ? NUM_VECTORS_C : capacity_q;

  avba_seq u_seq (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .enabled_i      (enabled_q),
    .cap_i          (eff_cap),
    .in_valid_i     (s_axis_tvalid),
    .in_ready_o     (s_axis_tready),
    .in_cmd_i       (s_axis_tuser),
    .in_count_i     (s_axis_tdata[CNT_W-1:0]),
    .in_align_i     (s_axis_tdata[2*CNT_W-1:CNT_W]),
    .in_base_i      (s_axis_tdata[2*CNT_W+VEC_W-1:2*CNT_W]),
    .res_valid_o    (res_valid),
    .res_ready_i    (res_ready),
    .res_o          (res),
    .map_req_o      (map_req),
    .map_rdata_i    (map_rdata),
    .map_clearing_i (map_clearing)
  );

  avba_map u_map (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_i      (map_req),
    .rdata_o    (map_rdata),
    .clearing_o (map_clearing)
  );

  // Output register: take a new result when the slot is empty or draining.
  assign res_ready = !out_valid_q || m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      out_q       <= '{status: ST_OK, base: '0};
    end else begin
      if (res_valid && res_ready) begin
        out_valid_q <= 1'b1;
        out_q       <= res;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {(OUT_DATA_W - VEC_W - 2)'(0), out_q.base, out_q.status};

endmodule

// ===== hdl/avba_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// avba_checker
// Port-level checks of the allocator, bound to the top level.
// ----------------------------------------------------------------------------
module avba_checker (
  input logic                                 clk_i,
  input logic                                 rst_ni,
  input logic                                 s_axis_tvalid,
  input logic                                 s_axis_tready,
  input logic                                 m_axis_tvalid,
  input logic                                 m_axis_tready,
  input logic [avba_pkg::OUT_DATA_W-1:0]      m_axis_tdata
);
  import avba_pkg::*;

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  // Only a successful allocate carries a nonzero base.
  a_base_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tdata[1:0] != ST_OK) |-> (m_axis_tdata[9:2] == '0))
    else $error("nonzero base on a failed request");

  // One item at a time: no acceptance in the cycle after one.
  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("item accepted while the previous one is in work");

  // A result appears only while the block is busy with the item behind it.
  a_result_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(!s_axis_tready))
    else $error("result appeared without an item in work");

endmodule

bind aligned_vector_block_allocator avba_checker u_avba_checker (.*);

// ===== tb/avba_tb_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// avba_tb_pkg
// Request codes and the request record shared by the allocator testbench.
// ----------------------------------------------------------------------------
package avba_tb_pkg;

  typedef enum logic {
    CMD_ALLOC = 1'b0,
    CMD_FREE  = 1'b1
  } cmd_e;

  typedef struct packed {
    cmd_e                        cmd;
    logic [avba_pkg::CNT_W-1:0]  count;
    logic [avba_pkg::CNT_W-1:0]  align;
    logic [avba_pkg::VEC_W-1:0]  base;
  } vec_req_t;

endpackage

// ===== tb/vector_alloc_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vector_alloc_checker
// Watches the request and result streams of the vector allocator, keeps its
// own busy map and register copy, predicts every result and compares it.
// ----------------------------------------------------------------------------
module vector_alloc_checker (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [avba_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [avba_pkg::CFG_DATA_W-1:0]    cfg_wdata_i,
  input  logic                               s_axis_tvalid,
  input  logic                               s_axis_tready,
  input  logic [avba_pkg::IN_DATA_W-1:0]     s_axis_tdata,
  input  logic                               s_axis_tuser,
  input  logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  input  logic [avba_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
  output int                                 fail_cnt_o,
  output int                                 pending_o,
  output int                                 req_cnt_o,
  output int                                 ok_cnt_o,
  output int                                 invalid_cnt_o,
  output int                                 no_block_cnt_o,
  output int                                 not_ready_cnt_o
);
  import avba_pkg::*;
  import avba_tb_pkg::*;

  logic [NUM_VECTORS-1:0] busy_map;
  logic                   enabled;
  logic [CFG_DATA_W-1:0]  capacity;
  result_t                grant_q[$];

  int fail_cnt, pending, req_cnt;
  int ok_cnt, invalid_cnt, no_block_cnt, not_ready_cnt;

  assign fail_cnt_o      = fail_cnt;
  assign pending_o       = pending;
  assign req_cnt_o       = req_cnt;
  assign ok_cnt_o        = ok_cnt;
  assign invalid_cnt_o   = invalid_cnt;
  assign no_block_cnt_o  = no_block_cnt;
  assign not_ready_cnt_o = not_ready_cnt;

  task automatic flag(input string what);
    fail_cnt++;
    if (fail_cnt <= 10) begin
      $display("[%0t] mismatch: %s", $time, what);
    end
  endtask

  // First fit over aligned starts; updates the busy map as the block would.
  task automatic predict_grant(input vec_req_t rq, output result_t res);
    int cap, cnt, step, start, k;
    bit fits, found;
    cap = (capacity > NUM_VECTORS) ? NUM_VECTORS : int'(capacity);
    cnt = int'(rq.count);
    res.status = ST_OK;
    res.base   = '0;
    if (!enabled) begin
      res.status = ST_NOT_READY;
    end else if (rq.cmd == CMD_ALLOC) begin
      step = (rq.align == '0) ? 1 : int'(rq.align);
      if (cnt == 0 || cnt > cap || (step & (step - 1)) != 0) begin
        res.status = ST_INVALID;
      end else begin
        res.status = ST_NO_BLOCK;
        found = 1'b0;
        for (start = 0; !found && start < cap && start + cnt <= cap; start += step) begin
          fits = 1'b1;
          for (k = 0; k < cnt; k++) begin
            if (busy_map[start + k]) fits = 1'b0;
          end
          if (fits) begin
            for (k = 0; k < cnt; k++) busy_map[start + k] = 1'b1;
            res.status = ST_OK;
            res.base   = VEC_W'(start);
            found      = 1'b1;
          end
        end
      end
    end else begin
      if (cnt == 0 || int'(rq.base) + cnt > cap) begin
        res.status = ST_INVALID;
      end else begin
        for (k = 0; k < cnt; k++) busy_map[int'(rq.base) + k] = 1'b0;
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : watch
    vec_req_t         rq;
    result_t          want;
    logic [1:0]       got_st;
    logic [VEC_W-1:0] got_base;
    logic [5:0]       got_pad;
    if (!rst_ni) begin
      busy_map      = '0;
      enabled       = 1'b0;
      capacity      = '0;
      grant_q.delete();
      pending       = 0;
      fail_cnt      = 0;
      req_cnt       = 0;
      ok_cnt        = 0;
      invalid_cnt   = 0;
      no_block_cnt  = 0;
      not_ready_cnt = 0;
    end else begin
      if (cfg_we_i) begin
        case (reg_idx_e'(cfg_idx_i))
          REG_ENABLED:  enabled  = cfg_wdata_i[0];
          REG_CAPACITY: capacity = cfg_wdata_i;
          default: ;
        endcase
      end
      if (s_axis_tvalid && s_axis_tready) begin
        rq.cmd   = cmd_e'(s_axis_tuser);
        rq.count = s_axis_tdata[8:0];
        rq.align = s_axis_tdata[17:9];
        rq.base  = s_axis_tdata[25:18];
        predict_grant(rq, want);
        grant_q.push_back(want);
        pending++;
        req_cnt++;
      end
      if (m_axis_tvalid && m_axis_tready) begin
        got_st   = m_axis_tdata[1:0];
        got_base = m_axis_tdata[9:2];
        got_pad  = m_axis_tdata[15:10];
        if (grant_q.size() == 0) begin
          flag($sformatf("result status %0d base %0d with no request pending",
                         got_st, got_base));
        end else begin
          want = grant_q.pop_front();
          pending--;
          if (got_st != want.status || got_base != want.base || got_pad != '0) begin
            flag($sformatf("expected status %0d base %0d, got status %0d base %0d pad %0h",
                           want.status, want.base, got_st, got_base, got_pad));
          end
          case (want.status)
            ST_OK:        ok_cnt++;
            ST_INVALID:   invalid_cnt++;
            ST_NO_BLOCK:  no_block_cnt++;
            default:      not_ready_cnt++;
          endcase
        end
      end
    end
  end

endmodule

// ===== tb/aligned_vector_block_allocator_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aligned_vector_block_allocator_tb
// Stimulus and verdict for the aligned vector block allocator.
// ----------------------------------------------------------------------------
// Drive a directed set of allocate and free requests through the edge cases
// (zero count, oversize count, bad alignment, full map, run at the capacity
// edge, disabled block, clamped and zero capacity), then random phases under
// several capacity settings. A side checker predicts and compares every
// result; this module only makes stimulus and reports the outcome.
// ----------------------------------------------------------------------------
module aligned_vector_block_allocator_tb;
  import avba_pkg::*;
  import avba_tb_pkg::*;

  localparam int CLK_PERIOD      = 10;
  localparam int RESET_CYCLES    = 12;
  localparam int NUM_PHASES      = 8;
  localparam int ITEMS_PER_PHASE = 225;
  localparam int HOLD_CYCLES     = 1500;
  localparam int DRAIN_CYCLES    = 64;
  // Watchdog bound for the whole run, stalls included.
  localparam int CYCLE_LIMIT     = 8_000_000;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_wdata_i;
  logic                  s_axis_tvalid;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata;
  logic                  s_axis_tuser;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready;
  logic [OUT_DATA_W-1:0] m_axis_tdata;

  int fail_cnt, pending, req_cnt;
  int ok_cnt, invalid_cnt, no_block_cnt, not_ready_cnt;
  int cycle_cnt;
  int n_settings;
  int sender_calm_left;
  bit hold_req;

  aligned_vector_block_allocator i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  vector_alloc_checker i_checker (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .s_axis_tvalid   (s_axis_tvalid),
    .s_axis_tready   (s_axis_tready),
    .s_axis_tdata    (s_axis_tdata),
    .s_axis_tuser    (s_axis_tuser),
    .m_axis_tvalid   (m_axis_tvalid),
    .m_axis_tready   (m_axis_tready),
    .m_axis_tdata    (m_axis_tdata),
    .fail_cnt_o      (fail_cnt),
    .pending_o       (pending),
    .req_cnt_o       (req_cnt),
    .ok_cnt_o        (ok_cnt),
    .invalid_cnt_o   (invalid_cnt),
    .no_block_cnt_o  (no_block_cnt),
    .not_ready_cnt_o (not_ready_cnt)
  );

  initial begin
    clk_i = 1'b0;
    forever #(CLK_PERIOD / 2) clk_i = ~clk_i;
  end

  // Watchdog: stop a hung run.
  initial begin
    cycle_cnt = 0;
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_cnt++;
    end
    $display("timeout after %0d cycles, %0d results outstanding", cycle_cnt, pending);
    $display("aligned_vector_block_allocator test failed");
    $finish;
  end

  // Sender idle gap: mostly back to back or short, a few long, and now and
  // then a burst with no gaps at all.
  function automatic int pick_gap();
    int pick;
    if (sender_calm_left > 0) begin
      sender_calm_left--;
      return 0;
    end
    pick = $urandom_range(0, 99);
    if (pick < 3) begin
      sender_calm_left = $urandom_range(10, 40);
      return 0;
    end
    if (pick < 60) return 0;
    if (pick < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 60);
  endfunction

  // Offer one item and hold it until the block takes it. Enter and leave
  // just after a rising edge, so valid only changes at falling edges.
  task automatic push_req(input vec_req_t rq);
    int gap;
    gap = pick_gap();
    @(negedge clk_i);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {6'd0, rq.base, rq.align, rq.count};
    s_axis_tuser  <= rq.cmd;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
  endtask

  task automatic send(input cmd_e cmd, input int count, input int align, input int base);
    vec_req_t rq;
    rq.cmd   = cmd;
    rq.count = CNT_W'(count);
    rq.align = CNT_W'(align);
    rq.base  = VEC_W'(base);
    push_req(rq);
  endtask

  // Drop valid and wait until every expected result has been taken. Each
  // item yields a result, so an empty scoreboard means the block is idle.
  task automatic wait_idle();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
  endtask

  task automatic write_reg(input reg_idx_e idx, input int value);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= CFG_DATA_W'(value);
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  function automatic int capacity_for_phase(input int ph);
    case (ph)
      0:       return 256;
      1:       return 64;
      2:       return 511;
      3:       return 17;
      4:       return 1;
      5:       return $urandom_range(2, 255);
      6:       return 256;
      default: return 128;
    endcase
  endfunction

  // Mostly well-formed traffic: small power-of-two aligned allocates and
  // frees of runs inside capacity; the rest is unconstrained noise.
  function automatic vec_req_t make_random_req(input int ecap);
    vec_req_t rq;
    int c, sel, pick, lo_base, room;
    c        = (ecap > 0) ? ecap : 1;
    sel      = $urandom_range(0, 99);
    rq.cmd   = CMD_ALLOC;
    rq.count = '0;
    rq.align = '0;
    rq.base  = '0;
    if (sel < 55) begin
      pick = $urandom_range(0, 99);
      if (pick < 70)      rq.count = CNT_W'($urandom_range(1, (c < 8) ? c : 8));
      else if (pick < 90) rq.count = CNT_W'($urandom_range(1, (c < 32) ? c : 32));
      else                rq.count = CNT_W'($urandom_range(1, c));
      pick = $urandom_range(0, 99);
      if (pick < 10)      rq.align = '0;
      else if (pick < 85) rq.align = CNT_W'(1 << $urandom_range(0, 4));
      else if (pick < 92) rq.align = CNT_W'(1 << $urandom_range(5, 8));
      else                rq.align = CNT_W'($urandom_range(0, 256));
      rq.base = VEC_W'($urandom);
    end else if (sel < 90) begin
      rq.cmd   = CMD_FREE;
      rq.align = CNT_W'($urandom_range(0, 256));
      if ($urandom_range(0, 19) == 0) begin
        // free every vector below the capacity now and then
        rq.count = CNT_W'(c);
      end else begin
        lo_base  = $urandom_range(0, c - 1);
        room     = c - lo_base;
        rq.base  = VEC_W'(lo_base);
        rq.count = CNT_W'($urandom_range(1, (room < 16) ? room : 16));
      end
    end else begin
      rq.cmd   = cmd_e'($urandom_range(0, 1));
      rq.count = CNT_W'($urandom_range(0, 256));
      rq.align = CNT_W'($urandom_range(0, 256));
      rq.base  = VEC_W'($urandom_range(0, 255));
    end
    return rq;
  endfunction

  // Result sink: random short stalls, rare long ones, calm stretches, and
  // a long hold-off on request so the block backs up into its input.
  initial begin : result_sink
    int stall_left, hold_left, mood_left, pick;
    bit calm;
    stall_left    = 0;
    hold_left     = 0;
    mood_left     = 0;
    calm          = 1'b0;
    m_axis_tready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (mood_left == 0) begin
        calm      = ($urandom_range(0, 3) == 0);
        mood_left = $urandom_range(100, 600);
      end else begin
        mood_left--;
      end
      if (hold_left > 0) begin
        m_axis_tready <= 1'b0;
        hold_left--;
      end else if (stall_left > 0) begin
        m_axis_tready <= 1'b0;
        stall_left--;
      end else begin
        m_axis_tready <= 1'b1;
        if (!calm) begin
          pick = $urandom_range(0, 99);
          if (pick < 10)      stall_left = $urandom_range(1, 3);
          else if (pick < 12) stall_left = $urandom_range(15, 80);
        end
      end
    end
  end

  initial begin : stimulus
    int ph, i, cap, ecap;
    rst_ni           = 1'b0;
    cfg_we_i         = 1'b0;
    cfg_idx_i        = REG_ENABLED;
    cfg_wdata_i      = '0;
    s_axis_tvalid    = 1'b0;
    s_axis_tdata     = '0;
    s_axis_tuser     = 1'b0;
    hold_req         = 1'b0;
    sender_calm_left = 0;
    n_settings       = 1;

    repeat (RESET_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Out of reset the block is disabled: both kinds answer not ready.
    // The first items also wait out the clearing pass of the busy map.
    send(CMD_ALLOC, 1, 1, 0);
    send(CMD_FREE, 1, 0, 0);
    wait_idle();

    write_reg(REG_CAPACITY, 256);
    write_reg(REG_ENABLED, 1);
    n_settings++;

    send(CMD_ALLOC, 0, 1, 0);      // zero count
    send(CMD_ALLOC, 256, 0, 0);    // whole map, alignment 0 taken as 1
    send(CMD_ALLOC, 1, 1, 0);      // map full, no room
    send(CMD_FREE, 0, 0, 0);       // zero count
    send(CMD_FREE, 2, 0, 255);     // run past capacity
    send(CMD_FREE, 256, 0, 0);     // release everything
    send(CMD_ALLOC, 1, 3, 0);      // alignment not a power of two
    send(CMD_ALLOC, 1, 256, 0);    // largest alignment, base 0
    send(CMD_ALLOC, 1, 256, 0);    // next aligned start is out of range
    send(CMD_ALLOC, 1, 128, 0);
    send(CMD_ALLOC, 4, 0, 0);      // first fit right after vector 0
    send(CMD_ALLOC, 8, 8, 0);
    send(CMD_FREE, 1, 0, 255);     // run ending exactly at capacity
    send(CMD_FREE, 1, 0, 255);     // already free, still fine
    send(CMD_ALLOC, 255, 1, 0);    // too long for any free run
    send(CMD_ALLOC, 2, 255, 255);  // all-ones alignment, invalid
    wait_idle();

    write_reg(REG_CAPACITY, 4);
    n_settings++;
    send(CMD_ALLOC, 5, 1, 0);      // count above capacity
    send(CMD_ALLOC, 1, 1, 0);      // vectors 0..4 busy, nothing left below 4
    send(CMD_FREE, 3, 0, 2);       // run past capacity
    wait_idle();

    // Disable: requests bounce, the map must survive.
    write_reg(REG_ENABLED, 0);
    n_settings++;
    send(CMD_ALLOC, 1, 1, 0);
    send(CMD_FREE, 1, 0, 0);
    wait_idle();

    // Capacity above the store depth clamps to the full map.
    write_reg(REG_CAPACITY, 511);
    write_reg(REG_ENABLED, 1);
    n_settings++;
    send(CMD_FREE, 256, 0, 0);
    send(CMD_ALLOC, 256, 256, 0);
    send(CMD_FREE, 256, 0, 0);
    wait_idle();

    write_reg(REG_CAPACITY, 0);
    n_settings++;
    send(CMD_ALLOC, 1, 1, 0);
    send(CMD_FREE, 1, 0, 0);
    wait_idle();

    // Random phases under a spread of capacities.
    for (ph = 0; ph < NUM_PHASES; ph++) begin
      wait_idle();
      cap  = capacity_for_phase(ph);
      ecap = (cap > NUM_VECTORS) ? NUM_VECTORS : cap;
      write_reg(REG_CAPACITY, cap);
      if (ph == 4) begin
        // a short disabled stretch inside this setting
        write_reg(REG_ENABLED, 0);
        n_settings++;
        for (i = 0; i < 15; i++) push_req(make_random_req(ecap));
        wait_idle();
        write_reg(REG_ENABLED, 1);
      end
      n_settings++;
      for (i = 0; i < ITEMS_PER_PHASE; i++) begin
        if (ph == 1 && i == 40) hold_req = 1'b1;  // sink backs off, input fills
        if (ph == 3 && i == 100) wait_idle();     // sender drains to idle
        push_req(make_random_req(ecap));
      end
    end

    wait_idle();
    repeat (DRAIN_CYCLES) @(negedge clk_i);

    $display("Covered %0d requests across %0d register settings.", req_cnt, n_settings);
    $display("Results: %0d granted or freed, %0d invalid, %0d no room, %0d disabled.",
             ok_cnt, invalid_cnt, no_block_cnt, not_ready_cnt);
    if (fail_cnt == 0 && pending == 0) begin
      $display("aligned_vector_block_allocator test passed");
    end else begin
      $display("%0d mismatches, %0d results outstanding", fail_cnt, pending);
      $display("aligned_vector_block_allocator test failed");
    end
    $finish;
  end

endmodule
